// ===== rtl/core/tpzs_pkg.sv =====
// shared types, constants and register map of the torus point z-buffer shader
`timescale 1ns / 1ps
package tpzs_pkg;

  localparam int MAX_WIDTH  = 512;
  localparam int MAX_HEIGHT = 512;
  localparam int XW         = $clog2(MAX_WIDTH);
  localparam int YW         = $clog2(MAX_HEIGHT);
  localparam int DEPTH      = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW         = $clog2(DEPTH);

  localparam int CAMERA_DIST  = 5;
  localparam int CAMERA_Z     = CAMERA_DIST * 4096;
  localparam int LUM_GAIN     = 8;
  localparam int LUM_SHIFT    = 14 - $clog2(LUM_GAIN);
  localparam int GRAY_STEP    = 23;
  localparam int GRAY_SAT_IDX = 255 / GRAY_STEP;

  localparam int OPW       = 25;
  localparam int PW        = 2 * OPW;
  localparam int SW        = 58;
  localparam int DIV_STEPS = 29;
  localparam int STEP_DIV  = 25;
  localparam int STEP_LAST = 30;

  typedef enum logic [1:0] {
    KIND_BEGIN  = 2'd0,
    KIND_SAMPLE = 2'd1,
    KIND_END    = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    ACT_CLEAR = 2'd0,
    ACT_DRAW  = 2'd1,
    ACT_SWAP  = 2'd2
  } action_e;

  typedef enum logic [2:0] {
    REG_TUBE   = 3'd0,
    REG_RING   = 3'd1,
    REG_SCALE  = 3'd2,
    REG_WIDTH  = 3'd3,
    REG_HEIGHT = 3'd4
  } reg_idx_e;

  typedef enum logic [1:0] {
    CS_IDLE,
    CS_MUL,
    CS_DIV,
    CS_FIN
  } calc_state_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CALC,
    ST_RD,
    ST_CMP,
    ST_EMIT
  } top_state_e;

  typedef struct packed {
    logic [15:0] tube;
    logic [15:0] ring;
    logic [23:0] scale;
    logic [9:0]  width;
    logic [9:0]  height;
  } cfg_t;

  typedef struct packed {
    logic signed [15:0] c1;
    logic signed [15:0] s1;
    logic signed [15:0] c2;
    logic signed [15:0] s2;
  } trig_t;

  typedef struct packed {
    logic          visible;
    logic [XW-1:0] x;
    logic [YW-1:0] y;
    logic [15:0]   ooz;
    logic [7:0]    gray;
  } calc_res_t;

endpackage

// ===== rtl/core/torus_point_zbuffer_shader_core.sv =====
// top level: config registers, item control, depth memory and result register
// a sample passes from transfer to result through the shared multiplier
// sequence (31 products) and the 29-step reciprocal divider
// end frame emits its swap result; begin frame emits its clear result, then sweeps the
// depth memory one entry a cycle (262144 entries) before taking the next item
// after reset the same sweep runs first; configuration writes are taken at any time
`timescale 1ns / 1ps
module torus_point_zbuffer_shader_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  kind_i,
  input  logic signed [15:0] first_cos_i,
  input  logic signed [15:0] first_sin_i,
  input  logic signed [15:0] second_cos_i,
  input  logic signed [15:0] second_sin_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  action_o,
  output logic [8:0]  pixel_x_o,
  output logic [8:0]  pixel_y_o,
  output logic [7:0]  gray_level_o
);
  import tpzs_pkg::*;

  cfg_t        cfg_q;
  trig_t       rot_q, smp_q, in_trig;
  top_state_e  state_q, state_d;
  action_e     pend_q, pend_d;
  calc_res_t   calc_res, res_q;
  logic        calc_start, calc_done;
  logic [AW-1:0] clr_q, mem_addr;
  logic        mem_we;
  logic [15:0] mem_wdata, rd_q;
  logic [15:0] depth_mem [DEPTH];
  logic        out_load;
  logic        take_rot, take_smp;

  assign pready  = 1'b1;
  assign in_trig = '{c1: first_cos_i, s1: first_sin_i, c2: second_cos_i, s2: second_sin_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{tube: 16'd4096, ring: 16'd8192, scale: 24'd38400,
                 width: 10'd480, height: 10'd480};
    end else if (psel && penable && pwrite) begin
      case (reg_idx_e'(paddr[4:2]))
        REG_TUBE:   cfg_q.tube   <= pwdata[15:0];
        REG_RING:   cfg_q.ring   <= pwdata[15:0];
        REG_SCALE:  cfg_q.scale  <= pwdata[23:0];
        REG_WIDTH:  cfg_q.width  <= pwdata[9:0];
        REG_HEIGHT: cfg_q.height <= pwdata[9:0];
        default:    cfg_q <= cfg_q;
      endcase
    end
  end

  always_comb begin
    case (reg_idx_e'(paddr[4:2]))
      REG_TUBE:   prdata = {16'd0, cfg_q.tube};
      REG_RING:   prdata = {16'd0, cfg_q.ring};
      REG_SCALE:  prdata = {8'd0, cfg_q.scale};
      REG_WIDTH:  prdata = {22'd0, cfg_q.width};
      REG_HEIGHT: prdata = {22'd0, cfg_q.height};
      default:    prdata = '0;
    endcase
  end

  tpzs_calc u_calc (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (calc_start),
    .cfg_i   (cfg_q),
    .rot_i   (rot_q),
    .smp_i   (smp_q),
    .done_o  (calc_done),
    .res_o   (calc_res)
  );

  always_comb begin
    state_d    = state_q;
    pend_d     = pend_q;
    in_ready_o = 1'b0;
    calc_start = 1'b0;
    take_rot   = 1'b0;
    take_smp   = 1'b0;
    mem_we     = 1'b0;
    mem_addr   = AW'(int'(res_q.x) * MAX_HEIGHT + int'(res_q.y));
    mem_wdata  = res_q.ooz;
    out_load   = 1'b0;
    case (state_q)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_addr  = clr_q;
        mem_wdata = '0;
        if (clr_q == AW'(DEPTH - 1)) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          case (kind_i)
            KIND_BEGIN: begin
              take_rot = 1'b1;
              pend_d   = ACT_CLEAR;
              state_d  = ST_EMIT;
            end
            KIND_SAMPLE: begin
              take_smp   = 1'b1;
              calc_start = 1'b1;
              state_d    = ST_CALC;
            end
            KIND_END: begin
              pend_d  = ACT_SWAP;
              state_d = ST_EMIT;
            end
            default: state_d = ST_IDLE;
          endcase
        end
      end
      ST_CALC: if (calc_done) state_d = calc_res.visible ? ST_RD : ST_IDLE;
      ST_RD: state_d = ST_CMP;
      ST_CMP: begin
        if (res_q.ooz > rd_q) begin
          mem_we  = 1'b1;
          pend_d  = ACT_DRAW;
          state_d = ST_EMIT;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_EMIT: begin
        if (!out_valid_o || out_ready_i) begin
          out_load = 1'b1;
          state_d  = (pend_q == ACT_CLEAR) ? ST_CLEAR : ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      pend_q      <= ACT_CLEAR;
      clr_q       <= '0;
      out_valid_o <= 1'b0;
      rot_q       <= '{c1: 16'sd16384, s1: 16'sd0, c2: 16'sd16384, s2: 16'sd0};
    end else begin
      state_q <= state_d;
      pend_q  <= pend_d;
      if (state_q == ST_CLEAR) clr_q <= (clr_q == AW'(DEPTH - 1)) ? '0 : clr_q + 1'b1;
      if (out_load) out_valid_o <= 1'b1;
      else if (out_ready_i) out_valid_o <= 1'b0;
      if (take_rot) rot_q <= in_trig;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_smp) smp_q <= in_trig;
    if (state_q == ST_CALC && calc_done) res_q <= calc_res;
    if (out_load) begin
      action_o     <= pend_q;
      pixel_x_o    <= (pend_q == ACT_DRAW) ? 9'(res_q.x) : '0;
      pixel_y_o    <= (pend_q == ACT_DRAW) ? 9'(res_q.y) : '0;
      gray_level_o <= (pend_q == ACT_DRAW) ? res_q.gray : '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) depth_mem[mem_addr] <= mem_wdata;
    rd_q <= depth_mem[mem_addr];
  end

`ifndef SYNTH
  a_we_states: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (state_q == ST_CMP || state_q == ST_CLEAR))
    else $error("depth write outside compare or clear");
  a_visible_reads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CALC && calc_done && calc_res.visible) |=> state_q == ST_RD)
    else $error("visible sample did not read depth");
  a_clear_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT && state_d == ST_CLEAR) |=> clr_q == '0)
    else $error("clear sweep not starting at entry zero");
  a_draw_nearer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT && pend_q == ACT_DRAW) |->
      ($past(state_q) == ST_CMP || $past(state_q) == ST_EMIT))
    else $error("draw emitted without depth compare");
`endif

endmodule

// ===== rtl/core/tpzs_calc.sv =====
// sequenced fixed-point unit: rotation, reciprocal depth, projection and lighting
`timescale 1ns / 1ps
module tpzs_calc (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  tpzs_pkg::cfg_t     cfg_i,
  input  tpzs_pkg::trig_t    rot_i,
  input  tpzs_pkg::trig_t    smp_i,
  output logic               done_o,
  output tpzs_pkg::calc_res_t res_o
);
  import tpzs_pkg::*;

  calc_state_e state_q, state_d;
  logic [4:0]  step_q;
  logic        phase_q;
  logic [4:0]  cnt_q;

  logic signed [OPW-1:0] a_w, b_w;
  logic signed [PW-1:0]  p_q, m_w;
  logic signed [OPW-1:0] cx_q, cy_q, t1_q, t2_q, t3_q, k_q, x_q, y_q, z_q, lum_q;
  logic [15:0]           ooz_q;
  logic [31:0]           scale_q;
  logic signed [SW-1:0]  acc_q, sx_q, sy_q;

  logic [23:0] rem_q, trial_w, dvs_w;
  logic [28:0] dvd_q, quo_q;

  logic [9:0]           w_eff, h_eff;
  logic signed [SW-1:0] nx_w, ny_w;
  logic                 xok, yok, zpos, lpos;
  logic [OPW-2-LUM_SHIFT:0] idx_w;

  assign m_w = p_q >>> 14;

  // operand select per step
  always_comb begin
    a_w = '0;
    b_w = '0;
    case (step_q)
      5'd0:  begin a_w = OPW'({1'b0, cfg_i.tube}); b_w = OPW'(smp_i.c1); end
      5'd1:  begin a_w = OPW'({1'b0, cfg_i.tube}); b_w = OPW'(smp_i.s1); end
      5'd2:  begin a_w = OPW'(rot_i.c2); b_w = OPW'(smp_i.c2); end
      5'd3:  begin a_w = OPW'(rot_i.s1); b_w = OPW'(rot_i.s2); end
      5'd4:  begin a_w = t2_q; b_w = OPW'(smp_i.s2); end
      5'd5:  begin a_w = OPW'(rot_i.c1); b_w = OPW'(rot_i.s2); end
      5'd6:  begin a_w = cx_q; b_w = k_q; end
      5'd7:  begin a_w = cy_q; b_w = t3_q; end
      5'd8:  begin a_w = OPW'(rot_i.s2); b_w = OPW'(smp_i.c2); end
      5'd9:  begin a_w = OPW'(rot_i.s1); b_w = OPW'(rot_i.c2); end
      5'd10: begin a_w = t2_q; b_w = OPW'(smp_i.s2); end
      5'd11: begin a_w = OPW'(rot_i.c1); b_w = OPW'(rot_i.c2); end
      5'd12: begin a_w = cx_q; b_w = k_q; end
      5'd13: begin a_w = cy_q; b_w = t3_q; end
      5'd14: begin a_w = cx_q; b_w = OPW'(rot_i.c1); end
      5'd15: begin a_w = t1_q; b_w = OPW'(smp_i.s2); end
      5'd16: begin a_w = cy_q; b_w = OPW'(rot_i.s1); end
      5'd17: begin a_w = OPW'(smp_i.c2); b_w = OPW'(smp_i.c1); end
      5'd18: begin a_w = t1_q; b_w = OPW'(rot_i.s2); end
      5'd19: begin a_w = OPW'(rot_i.c1); b_w = OPW'(smp_i.c1); end
      5'd20: begin a_w = t1_q; b_w = OPW'(smp_i.s2); end
      5'd21: begin a_w = OPW'(rot_i.s1); b_w = OPW'(smp_i.s1); end
      5'd22: begin a_w = OPW'(rot_i.c1); b_w = OPW'(smp_i.s1); end
      5'd23: begin a_w = OPW'(smp_i.c1); b_w = OPW'(rot_i.s1); end
      5'd24: begin a_w = t1_q; b_w = OPW'(smp_i.s2); end
      5'd25: begin a_w = OPW'(rot_i.c2); b_w = t2_q; end
      5'd26: begin a_w = OPW'({1'b0, cfg_i.scale}); b_w = OPW'({1'b0, ooz_q}); end
      5'd27: begin a_w = OPW'({1'b0, scale_q[15:0]}); b_w = x_q; end
      5'd28: begin a_w = OPW'({1'b0, scale_q[31:16]}); b_w = x_q; end
      5'd29: begin a_w = OPW'({1'b0, scale_q[15:0]}); b_w = y_q; end
      5'd30: begin a_w = OPW'({1'b0, scale_q[31:16]}); b_w = y_q; end
      default: begin a_w = '0; b_w = '0; end
    endcase
  end

  assign dvs_w   = {1'b0, z_q[22:0]};
  assign trial_w = {rem_q[22:0], dvd_q[28]};
  assign zpos    = !z_q[OPW-1] && (z_q != '0);

  always_comb begin
    state_d = state_q;
    case (state_q)
      CS_IDLE: if (start_i) state_d = CS_MUL;
      CS_MUL: begin
        if (phase_q) begin
          if (step_q == 5'(STEP_DIV)) state_d = zpos ? CS_DIV : CS_FIN;
          else if (step_q == 5'(STEP_LAST)) state_d = CS_FIN;
        end
      end
      CS_DIV: if (cnt_q == 5'(DIV_STEPS - 1)) state_d = CS_MUL;
      CS_FIN: state_d = CS_IDLE;
      default: state_d = CS_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CS_IDLE;
      step_q  <= '0;
      phase_q <= 1'b0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      case (state_q)
        CS_IDLE: begin
          step_q  <= '0;
          phase_q <= 1'b0;
        end
        CS_MUL: begin
          phase_q <= !phase_q;
          if (phase_q) step_q <= step_q + 5'd1;
          cnt_q <= '0;
        end
        CS_DIV: cnt_q <= cnt_q + 5'd1;
        default: cnt_q <= '0;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    p_q <= a_w * b_w;
    if (state_q == CS_MUL && phase_q) begin
      case (step_q)
        5'd0:  cx_q  <= OPW'({9'd0, cfg_i.ring}) + m_w[OPW-1:0];
        5'd1:  cy_q  <= m_w[OPW-1:0];
        5'd2:  t1_q  <= m_w[OPW-1:0];
        5'd3:  t2_q  <= m_w[OPW-1:0];
        5'd4:  k_q   <= t1_q + m_w[OPW-1:0];
        5'd5:  t3_q  <= m_w[OPW-1:0];
        5'd6:  x_q   <= m_w[OPW-1:0];
        5'd7:  x_q   <= x_q - m_w[OPW-1:0];
        5'd8:  t1_q  <= m_w[OPW-1:0];
        5'd9:  t2_q  <= m_w[OPW-1:0];
        5'd10: k_q   <= t1_q - m_w[OPW-1:0];
        5'd11: t3_q  <= m_w[OPW-1:0];
        5'd12: y_q   <= m_w[OPW-1:0];
        5'd13: y_q   <= y_q + m_w[OPW-1:0];
        5'd14: t1_q  <= m_w[OPW-1:0];
        5'd15: z_q   <= OPW'(CAMERA_Z) + m_w[OPW-1:0];
        5'd16: z_q   <= z_q + m_w[OPW-1:0];
        5'd17: t1_q  <= m_w[OPW-1:0];
        5'd18: lum_q <= m_w[OPW-1:0];
        5'd19: t1_q  <= m_w[OPW-1:0];
        5'd20: lum_q <= lum_q - m_w[OPW-1:0];
        5'd21: lum_q <= lum_q - m_w[OPW-1:0];
        5'd22: t2_q  <= m_w[OPW-1:0];
        5'd23: t1_q  <= m_w[OPW-1:0];
        5'd24: t2_q  <= t2_q - m_w[OPW-1:0];
        5'd25: lum_q <= lum_q + m_w[OPW-1:0];
        5'd26: scale_q <= p_q[39:8];
        5'd27: acc_q <= SW'(p_q);
        5'd28: sx_q  <= acc_q + (SW'(p_q) <<< 16);
        5'd29: acc_q <= SW'(p_q);
        5'd30: sy_q  <= acc_q + (SW'(p_q) <<< 16);
        default: acc_q <= acc_q;
      endcase
    end
    // restoring division of 2^28 by the depth
    if (state_q == CS_MUL && phase_q && step_q == 5'(STEP_DIV)) begin
      rem_q <= '0;
      dvd_q <= 29'h1000_0000;
      quo_q <= '0;
    end else if (state_q == CS_DIV) begin
      dvd_q <= {dvd_q[27:0], 1'b0};
      if (trial_w >= dvs_w) begin
        rem_q <= trial_w - dvs_w;
        quo_q <= {quo_q[27:0], 1'b1};
      end else begin
        rem_q <= trial_w;
        quo_q <= {quo_q[27:0], 1'b0};
      end
    end
    if (state_q == CS_DIV && cnt_q == 5'(DIV_STEPS - 1)) begin
      ooz_q <= (quo_q[27:15] != '0) ? 16'hffff : {quo_q[14:0], trial_w >= dvs_w};
    end
  end

  // screen test and shading
  assign w_eff = (int'(cfg_i.width) > MAX_WIDTH) ? 10'(MAX_WIDTH) : cfg_i.width;
  assign h_eff = (int'(cfg_i.height) > MAX_HEIGHT) ? 10'(MAX_HEIGHT) : cfg_i.height;
  assign nx_w  = $signed({21'd0, w_eff[9:1], 28'd0}) + sx_q;
  assign ny_w  = $signed({21'd0, h_eff[9:1], 28'd0}) - sy_q;
  assign xok   = (nx_w > -58'sd268435456) &&
                 (nx_w[SW-1] ? (w_eff != '0) : (nx_w[SW-2:28] < {19'd0, w_eff}));
  assign yok   = (ny_w > -58'sd268435456) &&
                 (ny_w[SW-1] ? (h_eff != '0) : (ny_w[SW-2:28] < {19'd0, h_eff}));
  assign lpos  = !lum_q[OPW-1] && (lum_q != '0);
  assign idx_w = lum_q[OPW-2:LUM_SHIFT];

  always_comb begin
    res_o.visible = zpos && xok && yok && lpos;
    res_o.x       = nx_w[SW-1] ? '0 : nx_w[28 +: XW];
    res_o.y       = ny_w[SW-1] ? '0 : ny_w[28 +: YW];
    res_o.ooz     = ooz_q;
    res_o.gray    = (int'(idx_w) > GRAY_SAT_IDX) ? 8'hff : 8'(int'(idx_w) * GRAY_STEP);
  end

  assign done_o = (state_q == CS_FIN);

endmodule

// ===== dv/tb.sv =====
// testbench for the torus point z-buffer shader core with a built-in predictor
`timescale 1ns / 1ps
module tb;
  import tpzs_pkg::*;

  localparam logic [1:0] KIND_UNKNOWN = 2'd3;
  localparam longint CYCLE_LIMIT = 6000000;
  localparam int SETTLE_CYCLES = 150;

  typedef struct {
    logic [1:0] action;
    logic [8:0] x;
    logic [8:0] y;
    logic [7:0] gray;
  } pixel_cmd_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [4:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic [1:0] kind_i = '0;
  logic signed [15:0] first_cos_i = '0, first_sin_i = '0;
  logic signed [15:0] second_cos_i = '0, second_sin_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic [1:0] action_o;
  logic [8:0] pixel_x_o, pixel_y_o;
  logic [7:0] gray_level_o;

  torus_point_zbuffer_shader_core dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // shadow state of the renderer
  longint rot_ca = 16384, rot_sa = 0, rot_cb = 16384, rot_sb = 0;
  longint tube_r = 4096, ring_r = 8192, proj_k = 38400, scr_w = 480, scr_h = 480;
  logic [15:0] zbuf [int];

  pixel_cmd_t pending_cmds [$];
  int mismatches = 0;
  longint cycles = 0;
  bit send_busy = 1'b0, recv_busy = 1'b0;
  int stall_left = 0;

  function automatic longint fm(longint a, longint b);
    return (a * b) >>> 14;
  endfunction

  function automatic longint tshr(longint v);
    return v >= 0 ? (v >>> 28) : -((-v) >>> 28);
  endfunction

  function automatic bit shade_point(logic [1:0] kind, longint c1, longint s1, longint c2,
                                     longint s2, output pixel_cmd_t cmd);
    longint cx, cy, kx, ky, x, y, z, ooz, sc, xp, yp, lum, idx, gray, w, h;
    int pos;
    cmd = '{ACT_CLEAR, 0, 0, 0};
    if (kind == KIND_BEGIN) begin
      rot_ca = c1; rot_sa = s1; rot_cb = c2; rot_sb = s2;
      zbuf.delete();
      return 1'b1;
    end
    if (kind == KIND_END) begin
      cmd.action = ACT_SWAP;
      return 1'b1;
    end
    if (kind != KIND_SAMPLE) return 1'b0;
    w = scr_w > MAX_WIDTH ? MAX_WIDTH : scr_w;
    h = scr_h > MAX_HEIGHT ? MAX_HEIGHT : scr_h;
    cx = ring_r + ((tube_r * c1) >>> 14);
    cy = (tube_r * s1) >>> 14;
    kx = fm(rot_cb, c2) + fm(fm(rot_sa, rot_sb), s2);
    ky = fm(rot_sb, c2) - fm(fm(rot_sa, rot_cb), s2);
    x = fm(cx, kx) - fm(cy, fm(rot_ca, rot_sb));
    y = fm(cx, ky) + fm(cy, fm(rot_ca, rot_cb));
    z = CAMERA_Z + fm(fm(cx, rot_ca), s2) + fm(cy, rot_sa);
    if (z <= 0) return 1'b0;
    ooz = (64'sd1 <<< 28) / z;
    if (ooz > 65535) ooz = 65535;
    sc = (proj_k * ooz) >>> 8;
    xp = tshr(((w / 2) <<< 28) + sc * x);
    yp = tshr(((h / 2) <<< 28) - sc * y);
    if (xp < 0 || xp >= w || yp < 0 || yp >= h) return 1'b0;
    lum = fm(fm(c2, c1), rot_sb) - fm(fm(rot_ca, c1), s2) - fm(rot_sa, s1)
        + fm(rot_cb, fm(rot_ca, s1) - fm(fm(c1, rot_sa), s2));
    if (lum <= 0) return 1'b0;
    pos = int'(xp * MAX_HEIGHT + yp);
    if (zbuf.exists(pos) && ooz <= zbuf[pos]) return 1'b0;
    zbuf[pos] = ooz[15:0];
    idx = (lum * LUM_GAIN) >>> 14;
    gray = idx > 255 ? 255 : idx * GRAY_STEP;
    if (gray > 255) gray = 255;
    cmd = '{ACT_DRAW, xp[8:0], yp[8:0], gray[7:0]};
    return 1'b1;
  endfunction

  task automatic send_item(logic [1:0] kind, logic [15:0] c1, logic [15:0] s1,
                           logic [15:0] c2, logic [15:0] s2);
    pixel_cmd_t cmd;
    int gap;
    in_valid_i <= 1'b1;
    kind_i <= kind;
    first_cos_i <= c1; first_sin_i <= s1;
    second_cos_i <= c2; second_sin_i <= s2;
    do @(posedge clk_i); while (!in_ready_o);
    if (shade_point(kind, longint'($signed(c1)), longint'($signed(s1)),
                    longint'($signed(c2)), longint'($signed(s2)), cmd))
      pending_cmds.push_back(cmd);
    gap = send_busy ? $urandom_range(0, 6) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic send_angles(logic [1:0] kind, bit noisy);
    real a, b;
    if (noisy) begin
      send_item(kind, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
    end else begin
      a = $urandom_range(0, 62831) / 10000.0;
      b = $urandom_range(0, 62831) / 10000.0;
      send_item(kind, 16'($rtoi($cos(a) * 16384.0)), 16'($rtoi($sin(a) * 16384.0)),
                16'($rtoi($cos(b) * 16384.0)), 16'($rtoi($sin(b) * 16384.0)));
    end
  endtask

  task automatic write_reg(reg_idx_e idx, logic [31:0] value);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= 5'(4 * int'(idx)); pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      REG_TUBE:   tube_r = value[15:0];
      REG_RING:   ring_r = value[15:0];
      REG_SCALE:  proj_k = value[23:0];
      REG_WIDTH:  scr_w = value[9:0];
      REG_HEIGHT: scr_h = value[9:0];
      default: ;
    endcase
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (pending_cmds.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  task automatic set_geometry(logic [31:0] t, logic [31:0] r, logic [31:0] k,
                              logic [31:0] w, logic [31:0] h);
    wait_idle();
    write_reg(REG_TUBE, t);
    write_reg(REG_RING, r);
    write_reg(REG_SCALE, k);
    write_reg(REG_WIDTH, w);
    write_reg(REG_HEIGHT, h);
  endtask

  task automatic test_directed();
    send_busy = 1'b0; recv_busy = 1'b0;
    // samples before any begin frame use the reset rotation
    send_item(KIND_SAMPLE, 16384, 0, 16384, 0);
    send_item(KIND_SAMPLE, 0, 16384, 0, 16384);
    send_item(KIND_SAMPLE, 16384, 0, 16384, 0);
    send_item(KIND_UNKNOWN, 16'h7fff, 16'h8000, 16'hffff, 16'h0001);
    send_item(KIND_END, 16'h8000, 16'h7fff, 0, 0);
    send_item(KIND_BEGIN, 11585, 11585, 14189, 8192);
    send_item(KIND_SAMPLE, -16384, 0, 16384, 0);
    send_item(KIND_SAMPLE, 0, -16384, 0, -16384);
    send_item(KIND_SAMPLE, 16384, 0, -16384, 0);
    send_item(KIND_SAMPLE, 16'h8000, 16'h8000, 16'h7fff, 16'h7fff);
    send_item(KIND_SAMPLE, 16'h7fff, 16'h7fff, 16'h8000, 16'h8000);
    send_item(KIND_SAMPLE, 11585, -11585, 11585, 11585);
    send_item(KIND_SAMPLE, 11585, -11585, 11585, 11585);
    send_item(KIND_SAMPLE, 0, 0, 0, 0);
    send_item(KIND_UNKNOWN, 0, 0, 0, 0);
    send_item(KIND_END, 0, 0, 0, 0);
  endtask

  task automatic test_extreme_geometry();
    set_geometry(32'hffff, 32'hffff, 32'hffffff, 32'h3ff, 32'h3ff);
    send_busy = 1'b1; recv_busy = 1'b1;
    repeat (40) send_angles(KIND_SAMPLE, $urandom_range(0, 3) == 0);
    set_geometry(0, 0, 0, 0, 0);
    repeat (15) send_angles(KIND_SAMPLE, $urandom_range(0, 3) == 0);
    set_geometry(4096, 8192, 38400, 1, 1);
    repeat (30) send_angles(KIND_SAMPLE, 1'b0);
    set_geometry(16384, 2048, 200000, 512, 300);
    repeat (60) send_angles(KIND_SAMPLE, $urandom_range(0, 3) == 0);
    send_item(KIND_END, 0, 0, 0, 0);
  endtask

  task automatic test_random_frame(bit with_begin, int count);
    set_geometry($urandom_range(2048, 6000), $urandom_range(6000, 12000),
                 $urandom_range(20000, 60000), $urandom_range(1, 512),
                 $urandom_range(1, 512));
    if (with_begin) send_angles(KIND_BEGIN, 1'b0);
    for (int i = 0; i < count; i++) begin
      if (i % 150 == 0) begin
        send_busy = $urandom_range(0, 2) != 0;
        recv_busy = $urandom_range(0, 2) != 0;
      end
      case ($urandom_range(0, 39))
        0: send_item(KIND_UNKNOWN, 16'($urandom), 16'($urandom), 16'($urandom),
                     16'($urandom));
        1: send_item(KIND_END, 16'($urandom), 16'($urandom), 16'($urandom),
                     16'($urandom));
        2, 3, 4: send_angles(KIND_SAMPLE, 1'b1);
        default: send_angles(KIND_SAMPLE, 1'b0);
      endcase
    end
    send_item(KIND_END, 0, 0, 0, 0);
  endtask

  // result side: random stalls on ready
  always @(posedge clk_i) begin
    if (out_valid_o && out_ready_i) begin
      stall_left <= recv_busy ? $urandom_range(0, 6) : 0;
      if (recv_busy && $urandom_range(0, 1)) out_ready_i <= 1'b0;
    end else if (!out_ready_i) begin
      if (stall_left <= 1) out_ready_i <= 1'b1;
      stall_left <= stall_left - 1;
    end
  end

  always @(posedge clk_i) begin
    pixel_cmd_t exp_cmd;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_cmds.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected transfer: action %0d x %0d y %0d gray %0d",
                   action_o, pixel_x_o, pixel_y_o, gray_level_o);
      end else begin
        exp_cmd = pending_cmds.pop_front();
        if (action_o !== exp_cmd.action || pixel_x_o !== exp_cmd.x ||
            pixel_y_o !== exp_cmd.y || gray_level_o !== exp_cmd.gray) begin
          mismatches++;
          if (mismatches <= 10)
            $display("exp action %0d x %0d y %0d gray %0d, got %0d %0d %0d %0d",
                     exp_cmd.action, exp_cmd.x, exp_cmd.y, exp_cmd.gray,
                     action_o, pixel_x_o, pixel_y_o, gray_level_o);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("torus_point_zbuffer_shader_core: mismatch");
      $finish;
    end
  end

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_extreme_geometry();
    test_random_frame(1'b1, 890);
    test_random_frame(1'b0, 890);
    wait_idle();
    if (mismatches == 0 && pending_cmds.size() == 0)
      $display("torus_point_zbuffer_shader_core: match");
    else
      $display("torus_point_zbuffer_shader_core: mismatch");
    $finish;
  end
endmodule

// ===== sim.f =====
rtl/core/tpzs_pkg.sv
rtl/core/tpzs_calc.sv
rtl/core/torus_point_zbuffer_shader_core.sv
dv/tb.sv
